[rtl/mrcds_pkg.sv]
// ----------------------------------------------------------------------------
// mrcds_pkg
// shared types and codes for the matrix row, column and diagonal sums block
// ----------------------------------------------------------------------------
package mrcds_pkg;

   localparam int CFG_W   = 6;
   localparam int ELEM_W  = 32;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COUNT = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ROW  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_COL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MAIN = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ANTI = 2'd3;

   // one classified element, front to back
   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
      logic                     main_hit;
      logic                     anti_hit;
      logic                     row_end;
      logic                     mat_end;
   } item_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_COL,
      ST_MAIN,
      ST_ANTI
   } state_type;

endpackage

[rtl/mrcds_front.sv]
// ----------------------------------------------------------------------------
// mrcds_front
// config registers, position tracking and element classification
// ----------------------------------------------------------------------------
module mrcds_front #(
   parameter int MAX_DIM = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [mrcds_pkg::ELEM_W-1:0]    req_element,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mrcds_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mrcds_pkg::CFG_W-1:0]            csr_wdata,
   input  logic                                   q_ready,
   output logic                                   q_push,
   output mrcds_pkg::item_type                    q_item,
   output logic [$clog2(MAX_DIM+1)-1:0]           cols_dim,
   output logic                                   clear
);
   import mrcds_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam logic [CFG_W-1:0] MAX_C = CFG_W'(MAX_DIM);
   localparam logic [CFG_W-1:0] ONE_C = CFG_W'(1);

   logic [CFG_W-1:0] row_cnt_ff, row_cnt_in, col_cnt_ff, col_cnt_in;
   logic [POS_W-1:0] r_ff, r_in, c_ff, c_in;
   logic [CFG_W-1:0] rows_eff, cols_eff, r_w, c_w;
   logic             csr_wr, c_last, r_last;

   // zero reads as one, oversize saturates
   always_comb begin
      if (row_cnt_ff == '0) rows_eff = ONE_C;
      else if (row_cnt_ff > MAX_C) rows_eff = MAX_C;
      else rows_eff = row_cnt_ff;
      if (col_cnt_ff == '0) cols_eff = ONE_C;
      else if (col_cnt_ff > MAX_C) cols_eff = MAX_C;
      else cols_eff = col_cnt_ff;
   end

   assign cols_dim  = cols_eff[DIM_W-1:0];
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid;
   assign clear     = csr_wr;

   assign req_ready = q_ready;
   assign q_push    = req_valid && q_ready;

   assign r_w    = CFG_W'(r_ff);
   assign c_w    = CFG_W'(c_ff);
   assign c_last = (c_w + ONE_C) == cols_eff;
   assign r_last = (r_w + ONE_C) == rows_eff;

   always_comb begin
      q_item.element  = req_element;
      q_item.main_hit = (c_w == r_w);
      q_item.anti_hit = (r_w < cols_eff) && (c_w == (cols_eff - ONE_C - r_w));
      q_item.row_end  = c_last;
      q_item.mat_end  = c_last && r_last;
   end

   always_comb begin
      row_cnt_in = row_cnt_ff;
      col_cnt_in = col_cnt_ff;
      r_in       = r_ff;
      c_in       = c_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_ROW_COUNT: row_cnt_in = csr_wdata;
            CSR_COL_COUNT: col_cnt_in = csr_wdata;
            default: ;
         endcase
         r_in = '0;
         c_in = '0;
      end else if (q_push) begin
         if (c_last) begin
            c_in = '0;
            r_in = r_last ? '0 : POS_W'(r_w + ONE_C);
         end else begin
            c_in = POS_W'(c_w + ONE_C);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= ONE_C;
         col_cnt_ff <= ONE_C;
         r_ff       <= '0;
         c_ff       <= '0;
      end else begin
         row_cnt_ff <= row_cnt_in;
         col_cnt_ff <= col_cnt_in;
         r_ff       <= r_in;
         c_ff       <= c_in;
      end
   end

endmodule

[rtl/mrcds_queue.sv]
// ----------------------------------------------------------------------------
// mrcds_queue
// two-entry queue of classified elements between front and back
// ----------------------------------------------------------------------------
module mrcds_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  logic                push,
   input  mrcds_pkg::item_type push_item,
   output logic                ready,
   input  logic                pop,
   output logic                valid,
   output mrcds_pkg::item_type pop_item,
   output logic                full
);
   import mrcds_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign ready    = !full;
   assign valid    = (cnt_ff != 2'd0);
   assign do_pop   = pop && valid;
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (clear) begin
         wr_in  = 1'b0;
         rd_in  = 1'b0;
         cnt_in = 2'd0;
      end else begin
         if (push && !full) wr_in = !wr_ff;
         if (do_pop) rd_in = !rd_ff;
         if ((push && !full) && !do_pop) cnt_in = cnt_ff + 2'd1;
         else if (!(push && !full) && do_pop) cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) mem_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

[rtl/mrcds_back.sv]
// ----------------------------------------------------------------------------
// mrcds_back
// accumulators, column ring, drain sequencer and output register
// ----------------------------------------------------------------------------
module mrcds_back #(
   parameter int MAX_DIM = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   clear,
   input  logic [$clog2(MAX_DIM+1)-1:0]           cols_dim,
   input  logic                                   q_valid,
   input  mrcds_pkg::item_type                    q_item,
   output logic                                   q_pop,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [mrcds_pkg::KIND_W-1:0]           rsp_sum_kind,
   output logic signed [mrcds_pkg::ELEM_W-1:0]    rsp_sum_value,
   output logic                                   rsp_last
);
   import mrcds_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   state_type state_ff, state_in;

   logic [ELEM_W-1:0] row_ff, row_in, main_ff, main_in, anti_ff, anti_in;
   logic [ELEM_W-1:0] col_ff [MAX_DIM];
   logic [ELEM_W-1:0] tail_val, row_sum;
   logic [DIM_W-1:0]  cnt_ff, cnt_in, cols_m1;

   logic              out_free, load, col_step, col_add, diag_clear;
   logic [KIND_W-1:0] kind_o;
   logic [ELEM_W-1:0] value_o;
   logic              last_o;

   logic              rsp_valid_ff, rsp_valid_in, rsp_last_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [ELEM_W-1:0] rsp_value_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cols_m1  = cols_dim - DIM_W'(1);
   assign row_sum  = row_ff + q_item.element;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN:  if (q_valid && out_free && q_item.mat_end) state_in = ST_COL;
         ST_COL:  if (out_free && cnt_ff == '0) state_in = ST_MAIN;
         ST_MAIN: if (out_free) state_in = ST_ANTI;
         ST_ANTI: if (out_free) state_in = ST_RUN;
         default: state_in = ST_RUN;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop      = 1'b0;
      load       = 1'b0;
      col_step   = 1'b0;
      col_add    = 1'b0;
      diag_clear = 1'b0;
      kind_o     = KIND_ROW;
      value_o    = row_sum;
      last_o     = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            q_pop    = q_valid && out_free;
            load     = q_pop && q_item.row_end;
            col_step = q_pop;
            col_add  = 1'b1;
         end
         ST_COL: begin
            load     = out_free;
            col_step = out_free;
            kind_o   = KIND_COL;
            value_o  = col_ff[0];
         end
         ST_MAIN: begin
            load    = out_free;
            kind_o  = KIND_MAIN;
            value_o = main_ff;
         end
         ST_ANTI: begin
            load       = out_free;
            diag_clear = out_free;
            kind_o     = KIND_ANTI;
            value_o    = anti_ff;
            last_o     = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      row_in  = row_ff;
      main_in = main_ff;
      anti_in = anti_ff;
      cnt_in  = cnt_ff;
      if (q_pop) begin
         row_in = q_item.row_end ? '0 : row_sum;
         if (q_item.main_hit) main_in = main_ff + q_item.element;
         if (q_item.anti_hit) anti_in = anti_ff + q_item.element;
         if (q_item.mat_end) cnt_in = cols_m1;
      end
      if (state_ff == ST_COL && out_free) cnt_in = cnt_ff - DIM_W'(1);
      if (diag_clear) begin
         main_in = '0;
         anti_in = '0;
      end
   end

   // column ring: head is the current column, drain refills with zero
   assign tail_val = col_add ? (col_ff[0] + q_item.element) : '0;

   for (genvar k = 0; k < MAX_DIM; k++) begin : g_ring
      localparam logic [DIM_W-1:0] K = DIM_W'(k);
      logic [ELEM_W-1:0] nxt;
      if (k + 1 < MAX_DIM) begin : g_mid
         assign nxt = (K < cols_m1) ? col_ff[k+1] : tail_val;
      end else begin : g_end
         assign nxt = tail_val;
      end
      always_ff @(posedge clock) begin
         if (reset || clear) begin
            col_ff[k] <= '0;
         end else if (col_step && K <= cols_m1) begin
            col_ff[k] <= nxt;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff  <= kind_o;
         rsp_value_ff <= value_o;
         rsp_last_ff  <= last_o;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         state_ff     <= ST_RUN;
         row_ff       <= '0;
         main_ff      <= '0;
         anti_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         main_ff      <= main_in;
         anti_ff      <= anti_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum_kind  = rsp_kind_ff;
   assign rsp_sum_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

[rtl/matrix_row_col_diag_sums_core.sv]
// ----------------------------------------------------------------------------
// matrix_row_col_diag_sums_core
// row, column and diagonal sums over a row-major stream of matrix elements
// ----------------------------------------------------------------------------
// usage
//   req channel: one element word per handshake, row-major order
//   rsp channel: one sum word per handshake, kind tags row, column, main
//     diagonal or anti-diagonal; last marks the anti-diagonal word
//   csr channel: index 0 row count, index 1 column count, always ready;
//     any write drops a matrix in progress and clears all sums
//   path: with the queue empty and the output free, a row sum is valid once
//     its last element has passed the queue entry and the output register
//   throughput: one element per cycle while the output is taken; after the
//     last element of a matrix the back end drains cols column sums plus
//     two diagonal sums, one per cycle while the output is taken, and takes no
//     element for that time (the two-entry queue still absorbs up to two elements)
//   stall: if rsp_ready is low the output register holds, the queue fills
//     and req_ready drops; nothing is lost
//   reset: synchronous, counts back to one, sums and queue cleared, no
//     clearing pass needed since the column ring is flip-flops
// ----------------------------------------------------------------------------
module matrix_row_col_diag_sums_core #(
   parameter int MAX_DIM = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [mrcds_pkg::ELEM_W-1:0]    req_element,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [mrcds_pkg::KIND_W-1:0]           rsp_sum_kind,
   output logic signed [mrcds_pkg::ELEM_W-1:0]    rsp_sum_value,
   output logic                                   rsp_last,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mrcds_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mrcds_pkg::CFG_W-1:0]            csr_wdata
);
   import mrcds_pkg::*;

   localparam int DIM_W = $clog2(MAX_DIM + 1);

   item_type         push_item, pop_item;
   logic             q_push, q_ready, q_pop, q_valid, q_full, clear;
   logic [DIM_W-1:0] cols_dim;

   // front end: config, row/column position, diagonal hits
   mrcds_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_element (req_element),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_item      (push_item),
      .cols_dim    (cols_dim),
      .clear       (clear)
   );

   // decoupling queue
   mrcds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .clear     (clear),
      .push      (q_push),
      .push_item (push_item),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (pop_item),
      .full      (q_full)
   );

   // back end: accumulate and drain sums
   mrcds_back #(.MAX_DIM(MAX_DIM)) u_back (
      .clock         (clock),
      .reset         (reset),
      .clear         (clear),
      .cols_dim      (cols_dim),
      .q_valid       (q_valid),
      .q_item        (pop_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sum_kind  (rsp_sum_kind),
      .rsp_sum_value (rsp_sum_value),
      .rsp_last      (rsp_last)
   );

   // last tags exactly the anti-diagonal word
   a_last_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_sum_kind == KIND_ANTI)))
      else $error("last flag does not match anti-diagonal kind");

   // the front never pushes into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into full queue");

   // a pop only happens when the queue holds an entry
   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

endmodule

[tb/matrix_row_col_diag_sums_checker.sv]
// ----------------------------------------------------------------------------
// matrix_row_col_diag_sums_checker
// watches the element, sum and csr channels of the sums core, works out
// the sum words each taken element should cause and compares them in order
// ----------------------------------------------------------------------------
module matrix_row_col_diag_sums_checker #(
   parameter int MAX_DIM = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [mrcds_pkg::ELEM_W-1:0]        req_element,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic [mrcds_pkg::KIND_W-1:0]        rsp_sum_kind,
   input  logic [mrcds_pkg::ELEM_W-1:0]        rsp_sum_value,
   input  logic                                rsp_last,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [mrcds_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mrcds_pkg::CFG_W-1:0]         csr_wdata,
   output int                                  fault_count,
   output int                                  sums_pending
);
   import mrcds_pkg::*;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [ELEM_W-1:0] value;
      logic              last;
   } sum_word_type;

   sum_word_type      sums_due[$];
   logic [CFG_W-1:0]  rows_cfg;
   logic [CFG_W-1:0]  cols_cfg;
   logic [ELEM_W-1:0] row_sum;
   logic [ELEM_W-1:0] main_sum;
   logic [ELEM_W-1:0] anti_sum;
   logic [ELEM_W-1:0] col_sums [MAX_DIM];
   int unsigned       row_at;
   int unsigned       col_at;
   int                faults;

   // zero counts as one, anything past the ring size saturates
   function automatic int unsigned span_of(input logic [CFG_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > MAX_DIM) return MAX_DIM;
      return 32'(raw);
   endfunction

   task automatic clear_sums();
      row_sum  = '0;
      main_sum = '0;
      anti_sum = '0;
      foreach (col_sums[i]) col_sums[i] = '0;
      row_at = 0;
      col_at = 0;
   endtask

   task automatic fold_element(input logic [ELEM_W-1:0] e);
      int unsigned rows;
      int unsigned cols;
      rows = span_of(rows_cfg);
      cols = span_of(cols_cfg);
      if (row_at >= rows || col_at >= cols) clear_sums();
      row_sum += e;
      col_sums[col_at] += e;
      // diagonals only over the first min(rows, cols) rows
      if (row_at < cols) begin
         if (col_at == row_at) main_sum += e;
         if (col_at == cols - 1 - row_at) anti_sum += e;
      end
      if (col_at + 1 < cols) begin
         col_at++;
      end else begin
         sums_due.push_back(sum_word_type'{KIND_ROW, row_sum, 1'b0});
         row_sum = '0;
         col_at  = 0;
         if (row_at + 1 < rows) begin
            row_at++;
         end else begin
            for (int j = 0; j < cols; j++)
               sums_due.push_back(sum_word_type'{KIND_COL, col_sums[j], 1'b0});
            sums_due.push_back(sum_word_type'{KIND_MAIN, main_sum, 1'b0});
            sums_due.push_back(sum_word_type'{KIND_ANTI, anti_sum, 1'b1});
            clear_sums();
         end
      end
   endtask

   task automatic check_sum_word();
      sum_word_type want;
      if (sums_due.size() == 0) begin
         if (faults < 10)
            $display("checker: unexpected sum word kind %0d value %h last %0b",
                     rsp_sum_kind, rsp_sum_value, rsp_last);
         faults++;
      end else begin
         want = sums_due.pop_front();
         if (rsp_sum_kind !== want.kind || rsp_sum_value !== want.value ||
             rsp_last !== want.last) begin
            if (faults < 10)
               $display("checker: sum word mismatch, expected kind %0d value %h last %0b, %s",
                        want.kind, want.value, want.last, "got:");
            if (faults < 10)
               $display("checker:   got kind %0d value %h last %0b",
                        rsp_sum_kind, rsp_sum_value, rsp_last);
            faults++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sums_due.delete();
         rows_cfg = 6'd1;
         cols_cfg = 6'd1;
         clear_sums();
         faults = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_sum_word();
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROW_COUNT) rows_cfg = csr_wdata;
            else if (csr_index == CSR_COL_COUNT) cols_cfg = csr_wdata;
            clear_sums();
         end
         if (req_valid && req_ready) fold_element(req_element);
      end
      fault_count  <= faults;
      sums_pending <= sums_due.size();
   end

endmodule

[tb/matrix_row_col_diag_sums_core_tb.sv]
// ----------------------------------------------------------------------------
// matrix_row_col_diag_sums_core_tb
// drives element words through the sums core under random bursts and output
// stalls, reprograms the matrix shape between phases, and takes the verdict
// from the checker that sits beside the core
// ----------------------------------------------------------------------------
module matrix_row_col_diag_sums_core_tb;
   import mrcds_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 130;

   // output side behavior, each held for a random stretch
   typedef enum logic [1:0] {
      DRAIN_OPEN,
      DRAIN_COIN,
      DRAIN_SPARSE,
      DRAIN_CHOPPY
   } drain_mode_type;

   logic                    clock;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   logic signed [ELEM_W-1:0] req_element = '0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   logic [KIND_W-1:0]       rsp_sum_kind;
   logic signed [ELEM_W-1:0] rsp_sum_value;
   logic                    rsp_last;
   logic                    csr_valid   = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index   = CSR_ROW_COUNT;
   logic [CFG_W-1:0]        csr_wdata   = '0;

   int             fault_count;
   int             sums_pending;
   int             cycle_count = 0;
   int             burst_left  = 0;
   int             items_sent  = 0;
   drain_mode_type drain_mode  = DRAIN_OPEN;
   int             drain_left  = 0;

   matrix_row_col_diag_sums_core u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_element   (req_element),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sum_kind  (rsp_sum_kind),
      .rsp_sum_value (rsp_sum_value),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   matrix_row_col_diag_sums_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_element   (req_element),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sum_kind  (rsp_sum_kind),
      .rsp_sum_value (rsp_sum_value),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fault_count   (fault_count),
      .sums_pending  (sums_pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog: a hung handshake or a missing sum word ends up here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("matrix_row_col_diag_sums_core regression: fail");
         $finish;
      end
   end

   // sum word receiver: switches between always open, coin flip, mostly
   // stalled and long stall stretches, each held for a random stretch
   always @(posedge clock) begin
      if (drain_left == 0) begin
         drain_mode <= drain_mode_type'($urandom_range(0, 3));
         drain_left <= $urandom_range(16, 96);
      end else begin
         drain_left <= drain_left - 1;
      end
      case (drain_mode)
         DRAIN_OPEN:   rsp_ready <= 1'b1;
         DRAIN_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         DRAIN_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:      rsp_ready <= ((drain_left % 16) < 4);   // long stalls
      endcase
   end

   // zero reads as one, past 32 saturates
   function automatic int unsigned span_of(input logic [CFG_W-1:0] raw);
      if (raw == '0) return 1;
      if (raw > 32) return 32;
      return 32'(raw);
   endfunction

   // element mix: the signed extremes, minus one, small values near zero
   // and plenty of full-width noise so every bit toggles
   function automatic logic [ELEM_W-1:0] pick_element();
      case ($urandom_range(0, 9))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'hffff_ffff;
         3:       return 32'($urandom_range(0, 64)) - 32'd32;
         default: return $urandom();
      endcase
   endfunction

   // mostly small shapes, now and then zero or a count of 32 to 63
   function automatic logic [CFG_W-1:0] pick_dim();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return CFG_W'(32 + $urandom_range(0, 31));
         default: return CFG_W'($urandom_range(1, 5));
      endcase
   endfunction

   // one element word; bursts of 1..12 words with an optional idle gap between
   task automatic send_element(input logic [ELEM_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_element <= value;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_run(input int count);
      repeat (count) send_element(pick_element());
   endtask

   // hold off until every expected sum word is back, then give the core
   // time to finish any partial row it is still folding in
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sums_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both shape registers back to back; valid stays up across the pair
   task automatic program_dims(input logic [CFG_W-1:0] rows_raw,
                               input logic [CFG_W-1:0] cols_raw);
      csr_valid <= 1'b1;
      csr_index <= CSR_ROW_COUNT;
      csr_wdata <= rows_raw;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_COL_COUNT;
      csr_wdata <= cols_raw;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [CFG_W-1:0] rows_raw;
      logic [CFG_W-1:0] cols_raw;
      int               cells;
      int               mats;
      int               phase;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset shape is 1x1: every word is a whole matrix, four sums each
      send_element(32'h7fff_ffff);
      send_element(32'h8000_0000);
      settle();

      // 2x3, wide: sums wrap through both extremes, anti-diagonal at col 2-i
      program_dims(6'd2, 6'd3);
      send_element(32'h7fff_ffff);
      send_element(32'h0000_0001);
      send_element(32'hffff_ffff);
      send_element(32'h8000_0000);
      send_element(32'h8000_0000);
      send_element(32'h0000_0000);
      // two words into a new matrix, then a write drops it without output
      send_element(32'h0000_0005);
      send_element(32'hdead_beef);
      settle();

      // 3x2, tall: the third row sits below both diagonals
      program_dims(6'd3, 6'd2);
      send_element(32'hffff_fffb);
      send_element(32'h0000_0011);
      send_element(32'h4000_0000);
      send_element(32'h4000_0000);
      send_element(32'hffff_ffff);
      send_element(32'h0000_0003);
      settle();

      // random phases: first the two one-dimensional extremes (32 rows via
      // a zero column count, one row of a saturated 63 column count), then
      // random shapes with whole matrices and the odd abandoned one
      items_sent = 0;
      phase      = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (phase == 0) begin
            rows_raw = 6'd32;
            cols_raw = 6'd0;
         end else if (phase == 1) begin
            rows_raw = 6'd0;
            cols_raw = 6'd63;
         end else begin
            rows_raw = pick_dim();
            cols_raw = pick_dim();
            // keep big shapes cheap: at most 64 words per matrix
            if (span_of(rows_raw) * span_of(cols_raw) > 64)
               cols_raw = CFG_W'($urandom_range(1, 2));
         end
         phase++;
         settle();
         program_dims(rows_raw, cols_raw);
         cells = span_of(rows_raw) * span_of(cols_raw);
         mats  = (cells > 16) ? 1 : $urandom_range(1, 4);
         repeat (mats) begin
            send_run(cells);
            // now and then wait for the output side to drain completely
            if ($urandom_range(0, 3) == 0) settle();
         end
         // broken matrix: stop partway, the next shape write discards it
         if (cells > 1 && $urandom_range(0, 2) == 0)
            send_run($urandom_range(1, cells - 1));
      end

      settle();
      repeat (16) @(posedge clock);
      if (fault_count == 0)
         $display("matrix_row_col_diag_sums_core regression: pass");
      else
         $display("matrix_row_col_diag_sums_core regression: fail");
      $finish;
   end

endmodule
